FILE: hw/rtl/calendar_day_number_convert_defines.svh
// Assertion macros used by the checker file.
`ifndef CALENDAR_DAY_NUMBER_CONVERT_DEFINES_SVH
`define CALENDAR_DAY_NUMBER_CONVERT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("cdn assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("cdn assertion failed");

`endif

FILE: hw/rtl/cdn_pkg.sv
package cdn_pkg;

  localparam int unsigned Depth = 5;

  localparam logic [13:0] MaxYear      = 14'd9999;
  localparam logic [21:0] MaxDayNumber = 22'd3652365;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } opcode_e;

  // q / 25 for q < 4681: (q * 2622) >> 16
  localparam int unsigned Div25Shift = 16;
  localparam logic [11:0] Div25Mul   = 12'd2622;

  // x / 146097 for x < 2^24
  localparam int unsigned CentShift = 42;
  localparam logic [24:0] CentMul   =
    25'(((64'd1 << CentShift) + 64'd146096) / 64'd146097);

  // x / 1461 for x < 2^25
  localparam int unsigned QuadShift = 36;
  localparam logic [25:0] QuadMul   =
    26'(((64'd1 << QuadShift) + 64'd1460) / 64'd1461);

  // x / 306 for x < 2^14
  localparam int unsigned MonShift = 23;
  localparam logic [14:0] MonMul   =
    15'(((64'd1 << MonShift) + 64'd305) / 64'd306);

  typedef struct packed {
    logic               ok;
    logic signed [22:0] day_number;
  } enc_res_t;

  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } dec_res_t;

  // Days in month, February as a common year.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // floor((367*m - 1094) / 12)
  function automatic logic signed [9:0] month_base(input logic [3:0] m);
    logic signed [9:0] b;
    unique case (m)
      4'd1:    b = -10'sd61;
      4'd2:    b = -10'sd30;
      4'd3:    b = 10'sd0;
      4'd4:    b = 10'sd31;
      4'd5:    b = 10'sd61;
      4'd6:    b = 10'sd92;
      4'd7:    b = 10'sd122;
      4'd8:    b = 10'sd153;
      4'd9:    b = 10'sd184;
      4'd10:   b = 10'sd214;
      4'd11:   b = 10'sd245;
      4'd12:   b = 10'sd275;
      default: b = 10'sd0;
    endcase
    return b;
  endfunction

  // ceil((306*m - 5) / 10), month counted from March = 0
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] s;
    unique case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/cdn_encode.sv
module cdn_encode (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [13:0]       year_i,
  input  logic [3:0]        month_i,
  input  logic [4:0]        day_i,
  output cdn_pkg::enc_res_t res_o
);
  import cdn_pkg::*;

  // stage 1
  logic               s1_fmt_ok_d, s1_fmt_ok_q;
  logic               s1_in_len_d, s1_in_len_q;
  logic               s1_feb29_d, s1_feb29_q;
  logic [13:0]        s1_n_d, s1_n_q;
  logic signed [9:0]  s1_base_d, s1_base_q;
  logic [22:0]        s1_y367_d, s1_y367_q;
  logic [13:0]        s1_year_q;
  logic [4:0]         s1_day_q;
  // stage 2
  logic [25:0]        yprod, nprod;
  logic [7:0]         s2_yq_d, s2_yq_q;
  logic [7:0]         s2_nq_d, s2_nq_q;
  logic signed [24:0] s2_p_d, s2_p_q;
  logic               s2_fmt_ok_q, s2_in_len_q, s2_feb29_q;
  logic [13:0]        s2_year_q, s2_n_q;
  // stage 3
  logic [14:0]        ycent;
  logic               leap;
  logic               s3_ok_d, s3_ok_q;
  logic signed [24:0] s3_r_d, s3_r_q;
  // stages 4 and 5
  enc_res_t           s4_res_d, s4_res_q, s5_res_q;

  always_comb begin
    s1_fmt_ok_d = (year_i <= MaxYear) && (month_i >= 4'd1) && (month_i <= 4'd12)
                  && (day_i != 5'd0);
    s1_in_len_d = day_i <= month_len(month_i);
    s1_feb29_d  = (month_i == 4'd2) && (day_i == 5'd29);
    // January and February count toward the previous year; year 0 truncates to 0
    s1_n_d      = (month_i < 4'd3 && year_i != 14'd0) ? year_i - 14'd1 : year_i;
    // truncation toward zero lifts January of year 0 by one
    s1_base_d   = (year_i == 14'd0 && month_i == 4'd1) ? -10'sd60 : month_base(month_i);
    s1_y367_d   = 23'(year_i) * 23'd367;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_fmt_ok_q <= s1_fmt_ok_d;
      s1_in_len_q <= s1_in_len_d;
      s1_feb29_q  <= s1_feb29_d;
      s1_n_q      <= s1_n_d;
      s1_base_q   <= s1_base_d;
      s1_y367_q   <= s1_y367_d;
      s1_year_q   <= year_i;
      s1_day_q    <= day_i;
    end
  end

  always_comb begin
    yprod   = 26'(s1_year_q[13:2]) * 26'(Div25Mul);
    nprod   = 26'(s1_n_q[13:2]) * 26'(Div25Mul);
    s2_yq_d = yprod[Div25Shift +: 8];
    s2_nq_d = nprod[Div25Shift +: 8];
    s2_p_d  = $signed({2'b00, s1_y367_q})
              + $signed({{15{s1_base_q[9]}}, s1_base_q})
              + $signed({20'd0, s1_day_q})
              - $signed({10'd0, s1_n_q, 1'b0});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_yq_q     <= s2_yq_d;
      s2_nq_q     <= s2_nq_d;
      s2_p_q      <= s2_p_d;
      s2_fmt_ok_q <= s1_fmt_ok_q;
      s2_in_len_q <= s1_in_len_q;
      s2_feb29_q  <= s1_feb29_q;
      s2_year_q   <= s1_year_q;
      s2_n_q      <= s1_n_q;
    end
  end

  always_comb begin
    ycent   = 15'(s2_yq_q) * 15'd100;
    leap    = (s2_year_q[1:0] == 2'd0)
              && (({1'b0, s2_year_q} != ycent) || (s2_yq_q[1:0] == 2'd0));
    s3_ok_d = s2_fmt_ok_q && (s2_in_len_q || (s2_feb29_q && leap));
    s3_r_d  = s2_p_q
              + $signed({13'd0, s2_n_q[13:2]})
              - $signed({17'd0, s2_nq_q})
              + $signed({19'd0, s2_nq_q[7:2]});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_ok_q <= s3_ok_d;
      s3_r_q  <= s3_r_d;
    end
  end

  always_comb begin
    s4_res_d.ok         = s3_ok_q;
    s4_res_d.day_number = s3_ok_q ? s3_r_q[22:0] : 23'sd0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_res_q <= s4_res_d;
      s5_res_q <= s4_res_q;
    end
  end

  assign res_o = s5_res_q;

endmodule

FILE: hw/rtl/cdn_decode.sv
module cdn_decode (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [21:0]       day_number_i,
  output cdn_pkg::dec_res_t res_o
);
  import cdn_pkg::*;

  // stage 1: centuries
  logic        s1_nz_d, s1_nz_q;
  logic        s1_ok_d, s1_ok_q;
  logic [23:0] x1;
  logic [48:0] prod1;
  logic [6:0]  s1_y1_d, s1_y1_q;
  logic [21:0] s1_n_q;
  // stage 2: years
  logic [22:0] s2_n2_d, s2_n2_q;
  logic [24:0] x2;
  logic [50:0] prod2;
  logic [13:0] s2_y2_d, s2_y2_q;
  logic        s2_ok_q;
  // stage 3: day of year
  logic [24:0] ydays;
  logic [22:0] n3_full;
  logic [9:0]  s3_n3_d, s3_n3_q;
  logic [13:0] s3_y2_q;
  logic        s3_ok_q;
  // stage 4: month
  logic [13:0] x3;
  logic [28:0] prod3;
  logic [3:0]  s4_m_d, s4_m_q;
  logic [9:0]  s4_n3_q;
  logic [13:0] s4_y2_q;
  logic        s4_ok_q;
  // stage 5: day and calendar month
  logic [9:0]  dfull;
  dec_res_t    s5_res_d, s5_res_q;

  always_comb begin
    s1_nz_d = day_number_i != 22'd0;
    s1_ok_d = day_number_i <= MaxDayNumber;
    // (100n - 20) / 3652425 equals (4n - 1) / 146097 for n >= 1
    x1      = s1_nz_d ? {day_number_i, 2'b00} - 24'd1 : 24'd0;
    prod1   = 49'(x1) * 49'(CentMul);
    s1_y1_d = prod1[CentShift +: 7];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_nz_q <= s1_nz_d;
      s1_ok_q <= s1_ok_d;
      s1_y1_q <= s1_y1_d;
      s1_n_q  <= day_number_i;
    end
  end

  always_comb begin
    s2_n2_d = 23'(s1_n_q) + 23'(s1_y1_q) - 23'(s1_y1_q[6:2]);
    x2      = s1_nz_q ? {s2_n2_d, 2'b00} - 25'd1 : 25'd0;
    prod2   = 51'(x2) * 51'(QuadMul);
    s2_y2_d = prod2[QuadShift +: 14];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_n2_q <= s2_n2_d;
      s2_y2_q <= s2_y2_d;
      s2_ok_q <= s1_ok_q;
    end
  end

  always_comb begin
    ydays   = 25'(s2_y2_q) * 25'd1461;
    n3_full = s2_n2_q - ydays[24:2];
    s3_n3_d = n3_full[9:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_n3_q <= s3_n3_d;
      s3_y2_q <= s2_y2_q;
      s3_ok_q <= s2_ok_q;
    end
  end

  always_comb begin
    x3     = (s3_n3_q == 10'd0) ? 14'd0 : 14'(s3_n3_q) * 14'd10 - 14'd5;
    prod3  = 29'(x3) * 29'(MonMul);
    s4_m_d = prod3[MonShift +: 4];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_m_q  <= s4_m_d;
      s4_n3_q <= s3_n3_q;
      s4_y2_q <= s3_y2_q;
      s4_ok_q <= s3_ok_q;
    end
  end

  always_comb begin
    dfull       = s4_n3_q - 10'(month_start(s4_m_q));
    s5_res_d.ok = s4_ok_q;
    if (!s4_ok_q) begin
      s5_res_d.year  = 14'd0;
      s5_res_d.month = 4'd0;
      s5_res_d.day   = 5'd0;
    end else if (s4_m_q < 4'd10) begin
      s5_res_d.year  = s4_y2_q;
      s5_res_d.month = s4_m_q + 4'd3;
      s5_res_d.day   = dfull[4:0];
    end else begin
      // January and February belong to the next calendar year
      s5_res_d.year  = s4_y2_q + 14'd1;
      s5_res_d.month = s4_m_q - 4'd9;
      s5_res_d.day   = dfull[4:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_res_q <= s5_res_d;
    end
  end

  assign res_o = s5_res_q;

endmodule

FILE: hw/rtl/calendar_day_number_convert.sv
// Gregorian date <-> day number converter, five register stages.
// An accepted transaction passes through every stage to out_valid_o; one
// that arrived while the pipeline was held first waits in the input skid register.
// Throughput: one transaction per cycle; the pipeline holds only while a
// result is stalled at the output. Reset (rst_ni low) empties all stages.
module calendar_day_number_convert (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic [13:0]        year_in_i,
  input  logic [3:0]         month_in_i,
  input  logic [4:0]         day_in_i,
  input  logic [21:0]        day_number_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               valid_res_o,
  output logic signed [22:0] day_number_out_o,
  output logic [13:0]        year_out_o,
  output logic [3:0]         month_out_o,
  output logic [4:0]         day_out_o
);
  import cdn_pkg::*;

  logic             en;
  logic             skid_vld_d, skid_vld_q;
  logic             skid_op_q;
  logic [13:0]      skid_year_q;
  logic [3:0]       skid_month_q;
  logic [4:0]       skid_day_q;
  logic [21:0]      skid_dn_q;
  logic             src_vld;
  logic             src_op;
  logic [13:0]      src_year;
  logic [3:0]       src_month;
  logic [4:0]       src_day;
  logic [21:0]      src_dn;
  logic [Depth-1:0] vld_q;
  logic [Depth-1:0] op_q;
  enc_res_t         enc_res;
  dec_res_t         dec_res;
  logic             out_dec;

  // whole pipeline holds only when the output transaction is stalled
  assign en = !(vld_q[Depth-1] && out_stall_i);

  // skid register catches the transaction taken in a held cycle
  assign in_stall_o = skid_vld_q;

  always_comb begin
    if (en) begin
      skid_vld_d = 1'b0;
    end else if (in_valid_i && !skid_vld_q) begin
      skid_vld_d = 1'b1;
    end else begin
      skid_vld_d = skid_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
      vld_q      <= '0;
    end else begin
      skid_vld_q <= skid_vld_d;
      if (en) begin
        vld_q <= {vld_q[Depth-2:0], src_vld};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_valid_i && !skid_vld_q) begin
      skid_op_q    <= opcode_i;
      skid_year_q  <= year_in_i;
      skid_month_q <= month_in_i;
      skid_day_q   <= day_in_i;
      skid_dn_q    <= day_number_in_i;
    end
  end

  always_comb begin
    src_vld   = skid_vld_q || in_valid_i;
    src_op    = skid_vld_q ? skid_op_q    : opcode_i;
    src_year  = skid_vld_q ? skid_year_q  : year_in_i;
    src_month = skid_vld_q ? skid_month_q : month_in_i;
    src_day   = skid_vld_q ? skid_day_q   : day_in_i;
    src_dn    = skid_vld_q ? skid_dn_q    : day_number_in_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q <= {op_q[Depth-2:0], src_op};
    end
  end

  cdn_encode u_encode (
    .clk_i   (clk_i),
    .en_i    (en),
    .year_i  (src_year),
    .month_i (src_month),
    .day_i   (src_day),
    .res_o   (enc_res)
  );

  cdn_decode u_decode (
    .clk_i        (clk_i),
    .en_i         (en),
    .day_number_i (src_dn),
    .res_o        (dec_res)
  );

  assign out_dec          = opcode_e'(op_q[Depth-1]) == OP_DECODE;
  assign out_valid_o      = vld_q[Depth-1];
  assign valid_res_o      = out_dec ? dec_res.ok : enc_res.ok;
  assign day_number_out_o = out_dec ? 23'sd0 : enc_res.day_number;
  assign year_out_o       = out_dec ? dec_res.year : 14'd0;
  assign month_out_o      = out_dec ? dec_res.month : 4'd0;
  assign day_out_o        = out_dec ? dec_res.day : 5'd0;

endmodule

FILE: hw/rtl/cdn_checker.sv
`include "calendar_day_number_convert_defines.svh"

module cdn_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               valid_res_o,
  input logic signed [22:0] day_number_out_o,
  input logic [13:0]        year_out_o,
  input logic [3:0]         month_out_o,
  input logic [4:0]         day_out_o
);

  // a stalled result transaction stays and holds its payload
  `CDN_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(valid_res_o) && $stable(day_number_out_o)
    && $stable(year_out_o) && $stable(month_out_o) && $stable(day_out_o))

  // a rejected transaction reports all-zero fields
  `CDN_ASSERT_NOW(a_reject_zero, clk_i, rst_ni, out_valid_o && !valid_res_o,
    day_number_out_o == 23'sd0 && year_out_o == 14'd0 && month_out_o == 4'd0
    && day_out_o == 5'd0)

  // encode result: no date fields
  `CDN_ASSERT_NOW(a_encode_only, clk_i, rst_ni,
    out_valid_o && valid_res_o && month_out_o == 4'd0,
    year_out_o == 14'd0 && day_out_o == 5'd0)

  // decode result: calendar month and no day number
  `CDN_ASSERT_NOW(a_decode_only, clk_i, rst_ni,
    out_valid_o && valid_res_o && month_out_o != 4'd0,
    month_out_o <= 4'd12 && day_number_out_o == 23'sd0)

endmodule

bind calendar_day_number_convert cdn_checker u_cdn_checker (.*);
